// ===== rtl/l2srgb_pkg.sv =====
package l2srgb_pkg;

  // Default configuration of the encoder.
  localparam int FRAC_BITS_DEF      = 16;
  localparam int TABLE_SEGMENTS_DEF = 64;

  // The table covers ten octaves of input, from 2^-9 up to 2.
  localparam int OCTAVES = 10;
  localparam int OCT_W   = 4;

  // Fixed point precision used while the node values are worked out.
  localparam int RQ = 24;

  // Denominator that turns the scaled power into output units.
  localparam longint RND_DEN = 64'sd1000 * (64'sd1 <<< RQ);

  // The functions below run at elaboration only; they build the node table.

  function automatic longint unsigned qmul(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b) >> RQ;
  endfunction

  function automatic longint unsigned pow12(input longint unsigned y);
    longint unsigned y2;
    longint unsigned y4;
    longint unsigned y8;
    y2 = qmul(y, y);
    y4 = qmul(y2, y2);
    y8 = qmul(y4, y4);
    return qmul(y8, y4);
  endfunction

  // Largest y below 2^25 whose twelfth power does not exceed v.
  function automatic longint unsigned root12(input longint unsigned v);
    longint unsigned y;
    longint unsigned c;
    y = 64'd0;
    for (int b = RQ; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (pow12(c) <= v) begin
        y = c;
      end
    end
    return y;
  endfunction

  // Shift and subtract division of two unsigned values.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Value of table node k: 1.055 * x^(5/12) - 0.055 in output units, rounded
  // half upward, where x is the start of segment s of octave o.
  function automatic longint node_value(input int k, input int seg, input int frac);
    int              o;
    int              s;
    int              w;
    int              q;
    int              r;
    longint unsigned m;
    longint unsigned m2;
    longint unsigned m5;
    longint unsigned bv;
    longint unsigned av;
    longint unsigned prd;
    longint          t;
    longint          nn;
    o = 0;
    s = k;
    for (int i = 0; i <= OCTAVES; i++) begin
      if (s >= seg) begin
        s = s - seg;
        o = o + 1;
      end
    end
    m   = udiv(longint'(seg + s) << RQ, longint'(seg));
    m2  = qmul(m, m);
    m5  = qmul(qmul(m2, m2), m);
    bv  = root12(m5);
    w   = 5 * o + 3;
    q   = w / 12 - 4;
    r   = w % 12;
    av  = root12(64'd1 << (RQ + r));
    prd = qmul(av, bv) >> (-q);
    t   = longint'(prd) * 64'sd1055 - 64'sd55 * (64'sd1 <<< RQ);
    nn  = (t <<< frac) + RND_DEN / 2;
    if (nn >= 0) begin
      return nn / RND_DEN;
    end
    return -((-nn + RND_DEN - 1) / RND_DEN);
  endfunction

endpackage

// ===== rtl/linear_to_srgb_encode_unit.sv =====
// A beat accepted on the input passes through registers s1 to s5 in order and appears
// on the output from s5.
// Five register stages, each with its own valid bit; one beat per cycle while out_stall does not hold the output.
// Reset (rst, synchronous, active high) clears every valid bit; the datapath registers
// are not reset. The node table is constant and needs no set-up after reset.
module linear_to_srgb_encode_unit #(
  parameter int FRAC_BITS      = l2srgb_pkg::FRAC_BITS_DEF,
  parameter int TABLE_SEGMENTS = l2srgb_pkg::TABLE_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [FRAC_BITS+1:0] linear_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FRAC_BITS+3:0] srgb_value
);

  // Field widths: input is Q1.F, output is Q3.F.
  localparam int IN_W  = FRAC_BITS + 2;
  localparam int OUT_W = FRAC_BITS + 4;

  // Table geometry. Each of the ten octaves is split into SEG equal segments;
  // the table holds a start value and a slope step for every segment.
  localparam int SEG     = TABLE_SEGMENTS / l2srgb_pkg::OCTAVES;
  localparam int ENTRIES = l2srgb_pkg::OCTAVES * SEG;
  localparam int KW      = $clog2(ENTRIES);
  localparam int SW      = (SEG > 1) ? $clog2(SEG) : 1;
  localparam int OW      = l2srgb_pkg::OCT_W;
  localparam int NW      = FRAC_BITS + 2;

  // Position of the leading one, 0 .. FRAC_BITS.
  localparam int PW = $clog2(IN_W);

  // Linear branch. round(12.92 x) is split into 12 x plus floor((46 x + 25) / 50).
  // The second term is lifted by 50 * 2^(F+1) so that it never goes negative, then
  // divided by 50 through a multiplication by a rounded-up reciprocal, which is
  // exact for every numerator below 2^LW.
  localparam int     LNW        = FRAC_BITS + 9;
  localparam int     LW         = FRAC_BITS + 8;
  localparam int     LIN_DIV    = 50;
  localparam int     LIN_DIV_LG = 6;
  localparam int     LIN_SH     = LW + LIN_DIV_LG;
  localparam int     QW         = LW - LIN_DIV_LG + 1;
  localparam longint LIN_OFS_L  = 64'sd25 + 64'sd50 * (64'sd1 <<< (FRAC_BITS + 1));
  localparam longint unsigned LIN_MUL_L =
    ((64'd1 << LIN_SH) + LIN_DIV - 1) / LIN_DIV;

  localparam logic signed [LNW-1:0] LIN_K   = LNW'(46);
  localparam logic signed [LNW-1:0] LIN_OFS = LNW'(LIN_OFS_L);
  localparam logic        [LW:0]    LIN_MUL = (LW + 1)'(LIN_MUL_L);

  // Working width of the result before saturation.
  localparam int YW = FRAC_BITS + 7;
  localparam logic signed [YW-1:0] Y12    = YW'(12);
  localparam logic signed [YW-1:0] Y_BIAS = YW'(64'sd1 <<< (FRAC_BITS + 1));

  // x > 0.0031308 holds exactly when x exceeds this integer.
  localparam longint THRESH_L = (64'sd31308 <<< FRAC_BITS) / 64'sd10000000;
  localparam logic signed [IN_W-1:0] THRESH = IN_W'(THRESH_L);

  // Interpolation product and the bias that makes its shift truncate toward zero.
  localparam int PRW = 2 * FRAC_BITS + 3;
  localparam logic signed [PRW-1:0] TRUNC_ADJ = PRW'((64'sd1 <<< FRAC_BITS) - 1);

  // Constant tables: node value at the start of each segment, and the step to
  // the next node.
  logic signed [NW-1:0] node_rom [ENTRIES];
  logic signed [NW-1:0] dlt_rom  [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    assign node_rom[g] = NW'(l2srgb_pkg::node_value(g, SEG, FRAC_BITS));
    assign dlt_rom[g]  = NW'(l2srgb_pkg::node_value(g + 1, SEG, FRAC_BITS)
                             - l2srgb_pkg::node_value(g, SEG, FRAC_BITS));
  end

  // Pipeline registers. Stage 1 holds the input beat, stage 5 is the output.
  logic                    s1_valid;
  logic signed [IN_W-1:0]  s1_x;

  logic                    s2_valid;
  logic                    s2_pow;
  logic signed [IN_W-1:0]  s2_x;
  logic [OW-1:0]           s2_oct;
  logic [FRAC_BITS-1:0]    s2_mant;
  logic [LW-1:0]           s2_lnum;

  logic                    s3_valid;
  logic                    s3_pow;
  logic signed [IN_W-1:0]  s3_x;
  logic signed [NW-1:0]    s3_node;
  logic signed [NW-1:0]    s3_dlt;
  logic [FRAC_BITS-1:0]    s3_frac;
  logic [2*LW:0]           s3_lprod;

  logic                    s4_valid;
  logic                    s4_pow;
  logic signed [NW-1:0]    s4_node;
  logic signed [PRW-1:0]   s4_prod;
  logic signed [YW-1:0]    s4_ylin;

  logic                    s5_valid;
  logic signed [OUT_W-1:0] s5_y;

  // Each stage takes a new beat when it is empty or when the stage after it
  // moves on, so bubbles close up and a waiting result does not block input
  // while there is room further up.
  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;
  logic s4_rdy;
  logic s5_rdy;

  always_comb begin
    s5_rdy = !s5_valid || !out_stall;
    s4_rdy = !s4_valid || s5_rdy;
    s3_rdy = !s3_valid || s4_rdy;
    s2_rdy = !s2_valid || s3_rdy;
    s1_rdy = !s1_valid || s2_rdy;
  end

  assign in_stall   = !s1_rdy;
  assign out_valid  = s5_valid;
  assign srgb_value = s5_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid <= in_valid;
      end
      if (s2_rdy) begin
        s2_valid <= s1_valid;
      end
      if (s3_rdy) begin
        s3_valid <= s2_valid;
      end
      if (s4_rdy) begin
        s4_valid <= s3_valid;
      end
      if (s5_rdy) begin
        s5_valid <= s4_valid;
      end
    end
  end

  // Stage A: branch decision, normalisation and octave, linear numerator.
  logic                   pow_a;
  logic [PW-1:0]          lead_a;
  logic [PW-1:0]          shamt_a;
  logic [FRAC_BITS:0]     norm_a;
  logic [PW:0]            lead9_a;
  logic [OW-1:0]          oct_a;
  logic signed [LNW-1:0]  lnum_a;

  always_comb begin
    pow_a  = s1_x > THRESH;
    lead_a = '0;
    for (int i = 0; i < IN_W - 1; i++) begin
      if (s1_x[i]) begin
        lead_a = PW'(i);
      end
    end
    // The leading one is moved up to bit FRAC_BITS; the bits below it are the
    // position inside the octave, scaled to a common fraction.
    shamt_a = PW'(FRAC_BITS) - lead_a;
    norm_a  = s1_x[FRAC_BITS:0] << shamt_a;
    lead9_a = {1'b0, lead_a} + (PW + 1)'(9);
    if (lead9_a < (PW + 1)'(FRAC_BITS)) begin
      oct_a = '0;
    end else begin
      oct_a = OW'(lead9_a - (PW + 1)'(FRAC_BITS));
    end
    lnum_a = LNW'(s1_x) * LIN_K + LIN_OFS;
  end

  // Stage B: segment and weight, table read, reciprocal multiplication.
  logic [FRAC_BITS+SW-1:0] u_b;
  logic [SW-1:0]           seg_b;
  logic [KW-1:0]           idx_b;
  logic [2*LW:0]           lprod_b;

  always_comb begin
    u_b     = (FRAC_BITS + SW)'(s2_mant) * (FRAC_BITS + SW)'(SEG);
    seg_b   = u_b[FRAC_BITS+SW-1:FRAC_BITS];
    idx_b   = KW'(s2_oct) * KW'(SEG) + KW'(seg_b);
    lprod_b = (2 * LW + 1)'(s2_lnum) * (2 * LW + 1)'(LIN_MUL);
  end

  // Stage C: interpolation product; linear result assembled.
  logic signed [PRW-1:0] prod_c;
  logic [QW-1:0]         quot_c;
  logic signed [YW-1:0]  ylin_c;

  always_comb begin
    prod_c = PRW'(s3_dlt) * PRW'($signed({1'b0, s3_frac}));
    quot_c = s3_lprod[2*LW:LIN_SH];
    ylin_c = YW'(s3_x) * Y12 + YW'(quot_c) - Y_BIAS;
  end

  // Stage D: interpolated value, branch select and saturation.
  logic signed [PRW-1:0]          rnd_d;
  logic signed [PRW-FRAC_BITS-1:0] inc_d;
  logic signed [YW-1:0]           ypow_d;
  logic signed [YW-1:0]           y_d;
  logic signed [OUT_W-1:0]        sat_d;

  always_comb begin
    rnd_d  = s4_prod + (s4_prod[PRW-1] ? TRUNC_ADJ : '0);
    inc_d  = rnd_d[PRW-1:FRAC_BITS];
    ypow_d = YW'(s4_node) + YW'(inc_d);
    y_d    = s4_pow ? ypow_d : s4_ylin;
    // In range when every bit above the output's sign bit matches it.
    if ((y_d[YW-1:OUT_W-1] == '0) || (y_d[YW-1:OUT_W-1] == '1)) begin
      sat_d = y_d[OUT_W-1:0];
    end else if (y_d[YW-1]) begin
      sat_d = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_x <= linear_value;
    end
    if (s2_rdy) begin
      s2_pow  <= pow_a;
      s2_x    <= s1_x;
      s2_oct  <= oct_a;
      s2_mant <= norm_a[FRAC_BITS-1:0];
      s2_lnum <= lnum_a[LW-1:0];
    end
    if (s3_rdy) begin
      s3_pow   <= s2_pow;
      s3_x     <= s2_x;
      s3_node  <= node_rom[idx_b];
      s3_dlt   <= dlt_rom[idx_b];
      s3_frac  <= u_b[FRAC_BITS-1:0];
      s3_lprod <= lprod_b;
    end
    if (s4_rdy) begin
      s4_pow  <= s3_pow;
      s4_node <= s3_node;
      s4_prod <= prod_c;
      s4_ylin <= ylin_c;
    end
    if (s5_rdy) begin
      s5_y <= sat_d;
    end
  end

endmodule

// ===== rtl/l2srgb_checker.sv =====
module l2srgb_checker #(
  parameter int FRAC_BITS = l2srgb_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [FRAC_BITS+3:0] srgb_value
);

  // A held result stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(srgb_value))
  else $error("stalled result changed or was dropped");

  // Input is only held off when the pipeline is full behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
  else $error("input stalled while the output side can move");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !out_valid)
  else $error("result valid straight after reset");

  // With the output side free, an accepted beat reaches the output through stages s1 to s5.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid)
  else $error("accepted beat did not reach the output in time");

endmodule

bind linear_to_srgb_encode_unit l2srgb_checker #(.FRAC_BITS(FRAC_BITS)) u_l2srgb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .srgb_value (srgb_value)
);
